// ===== rtl/tsa_pkg.sv =====
// Shared types and constants for the tile slot allocator with byte budget.
// No dependencies; imported by the allocator core, the top level and the checker.
`default_nettype none
package tsa_pkg;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FRAME   = 2'd2,
    OP_RSVD    = 2'd3
  } tsa_op_t;

  localparam int unsigned SLOT_OUT_W   = 5;
  localparam int unsigned TOTAL_OUT_W  = 36;
  localparam int unsigned BUDGET_W     = 32;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd10485760;

  // Result of one request, as presented on the output channel
  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   failed;
    logic [TOTAL_OUT_W-1:0] total;
    logic                   over;
  } tsa_result_t;

  // Bytes per pixel as a left shift: 16, 8, 2, else 4
  function automatic logic [2:0] bpp_shift(input logic [3:0] code);
    logic [2:0] sh;
    case (code)
      4'd0:    sh = 3'd4;
      4'd1:    sh = 3'd3;
      4'd7:    sh = 3'd1;
      default: sh = 3'd2;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tsa_alloc_core.sv =====
// Slot table state, lowest-free search, running total and overflow flag.
// Depends on tsa_pkg; the size store itself lives in a tsa_ram outside.
`default_nettype none
module tsa_alloc_core #(
  parameter int NUM_SLOTS = 32,
  parameter int IDX_W     = 5,
  parameter int SIZE_W    = 32,
  parameter int TOT_W     = 38
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [tsa_pkg::BUDGET_W-1:0] budget,
  input  wire logic                         fire,
  input  wire tsa_pkg::tsa_op_t             op,
  input  wire logic [SIZE_W-1:0]            size,
  input  wire logic [5:0]                   rel_slot,
  input  wire logic [SIZE_W-1:0]            rel_bytes,
  output tsa_pkg::tsa_result_t              result,
  output logic                              wr_en,
  output logic      [IDX_W-1:0]             wr_addr,
  output logic      [SIZE_W-1:0]            wr_data
);
  import tsa_pkg::*;

  localparam int CMP_W = TOT_W + BUDGET_W;

  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [NUM_SLOTS-1:0] live_r, live_nxt;   // size recorded this frame
  logic [TOT_W-1:0]     total_r, total_nxt;
  logic                 over_r, over_nxt;

  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] rel_idx;
  logic             rel_in_range;
  logic             rel_ok;
  logic [SIZE_W-1:0] rel_sub;
  logic [TOT_W-1:0] alloc_total;
  logic             alloc_ok;
  logic             failed;

  // Lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Release checks; a size from an earlier frame counts as zero
  assign rel_idx      = rel_slot[IDX_W-1:0];
  assign rel_in_range = 7'(rel_slot) < 7'(NUM_SLOTS);
  assign rel_ok       = rel_in_range && in_use_r[rel_idx];
  assign rel_sub      = live_r[rel_idx] ? rel_bytes : '0;

  assign alloc_ok    = (size != '0) && found;
  assign alloc_total = total_r + TOT_W'(size);

  // Next state per operation
  always_comb begin
    in_use_nxt = in_use_r;
    live_nxt   = live_r;
    total_nxt  = total_r;
    over_nxt   = over_r;
    failed     = 1'b0;
    case (op)
      OP_ALLOC: begin
        failed = !alloc_ok;
        if (alloc_ok) begin
          in_use_nxt[free_idx] = 1'b1;
          live_nxt[free_idx]   = 1'b1;
          total_nxt            = alloc_total;
          if (CMP_W'(alloc_total) > CMP_W'(budget)) begin
            over_nxt = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        failed = !rel_ok;
        if (rel_ok) begin
          in_use_nxt[rel_idx] = 1'b0;
          total_nxt           = total_r - TOT_W'(rel_sub);
        end
      end
      OP_FRAME: begin
        live_nxt  = '0;
        total_nxt = '0;
        over_nxt  = 1'b0;
      end
      default: begin
        failed = 1'b1;
      end
    endcase
  end

  // Size store write for a granted slot
  assign wr_en   = fire && (op == OP_ALLOC) && alloc_ok;
  assign wr_addr = free_idx;
  assign wr_data = size;

  // Result of the request being processed
  assign result.slot   = ((op == OP_ALLOC) && alloc_ok) ? SLOT_OUT_W'(free_idx) : '0;
  assign result.failed = failed;
  assign result.total  = TOTAL_OUT_W'(total_nxt);
  assign result.over   = over_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      live_r   <= '0;
      total_r  <= '0;
      over_r   <= 1'b0;
    end else if (fire) begin
      in_use_r <= in_use_nxt;
      live_r   <= live_nxt;
      total_r  <= total_nxt;
      over_r   <= over_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tile_slot_allocator_budget_unit.sv =====
// Tile slot allocator with byte budget, top level.
// A request accepted into the input register moves on to the result register when it fires.
// One request per cycle while out_stall is low; the input register and the result
// register each hold one request, size multiply sits before the input register.
// Reset (rst_n low, synchronous): slot table, total, flag and budget (10485760)
// are set at once; the size store needs no clearing pass.
`default_nettype none
module tile_slot_allocator_budget_unit #(
  parameter int NUM_SLOTS = 32,
  parameter int DIM_BITS  = 14
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_en,
  input  wire logic [tsa_pkg::BUDGET_W-1:0]   cfg_write_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [DIM_BITS-1:0]            in_tile_width,
  input  wire logic [DIM_BITS-1:0]            in_tile_height,
  input  wire logic [3:0]                     in_format_code,
  input  wire logic [5:0]                     in_release_slot,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [tsa_pkg::SLOT_OUT_W-1:0]      out_slot_number,
  output logic                                out_failed,
  output logic [tsa_pkg::TOTAL_OUT_W-1:0]     out_total_bytes,
  output logic                                out_over_budget
);
  import tsa_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PROD_W = 2 * DIM_BITS;
  localparam int SIZE_W = PROD_W + 4;
  localparam int TOT_W  = SIZE_W + IDX_W + 1;

  logic [BUDGET_W-1:0] budget_r;

  logic              s1_valid_r;
  tsa_op_t           s1_op_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [5:0]        s1_rel_r;
  logic              byp_hit_r;
  logic [SIZE_W-1:0] byp_data_r;

  logic        out_valid_r;
  tsa_result_t out_r;

  logic              load_out, fire, accept;
  logic [PROD_W-1:0] prod;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] rd_data, rel_bytes;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [SIZE_W-1:0] wr_data;
  tsa_result_t       result;

  // Handshake: the result register frees the input register
  assign load_out = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && load_out;
  assign in_stall = s1_valid_r && !load_out;
  assign accept   = in_valid && !in_stall;

  // Byte size of the requested tile
  assign prod = PROD_W'(in_tile_width) * PROD_W'(in_tile_height);
  assign size = SIZE_W'(prod) << bpp_shift(in_format_code);

  // Budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_write_en) begin
      budget_r <= cfg_write_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload and write-to-read bypass for the size store
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= tsa_op_t'(in_operation);
      s1_size_r  <= size;
      s1_rel_r   <= in_release_slot;
      byp_hit_r  <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_addr   = in_release_slot[IDX_W-1:0];
  assign rel_bytes = byp_hit_r ? byp_data_r : rd_data;

  tsa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tsa_alloc_core #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W),
    .SIZE_W    (SIZE_W),
    .TOT_W     (TOT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .budget    (budget_r),
    .fire      (fire),
    .op        (s1_op_r),
    .size      (s1_size_r),
    .rel_slot  (s1_rel_r),
    .rel_bytes (rel_bytes),
    .result    (result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_number = out_r.slot;
  assign out_failed      = out_r.failed;
  assign out_total_bytes = out_r.total;
  assign out_over_budget = out_r.over;

endmodule
`default_nettype wire

// ===== rtl/tsa_checker.sv =====
// Port-level checks for the tile slot allocator top level, with its bind.
// Depends on tsa_pkg for field widths.
`default_nettype none
module tsa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [tsa_pkg::SLOT_OUT_W-1:0] out_slot_number,
  input wire logic                           out_failed,
  input wire logic [tsa_pkg::TOTAL_OUT_W-1:0] out_total_bytes,
  input wire logic                           out_over_budget
);
  import tsa_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot_number) &&
      $stable(out_failed) && $stable(out_total_bytes) && $stable(out_over_budget))
    else $error("stalled result changed");

  // Input stalls only under output backpressure
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // An accepted request leads to a pending result on the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // A failed request grants no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> out_slot_number == '0)
    else $error("failed request reports a slot");

endmodule

bind tile_slot_allocator_budget_unit tsa_checker u_tsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_slot_number (out_slot_number),
  .out_failed      (out_failed),
  .out_total_bytes (out_total_bytes),
  .out_over_budget (out_over_budget)
);
`default_nettype wire
